// ----- src/polar_spherical_to_cartesian_unit_macros.svh -----
// Assertion macros shared by the conversion unit.
`ifndef POLAR_SPHERICAL_TO_CARTESIAN_UNIT_MACROS_SVH
`define POLAR_SPHERICAL_TO_CARTESIAN_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psc assertion failed");

// Antecedent implies consequent a fixed number of cycles later.
`define PSC_ASSERT_DELAY(label, clk, rst_n, ante, cons, n) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("psc assertion failed");

`endif

// ----- src/psc_pkg.sv -----
package psc_pkg;

	localparam int DATA_BITS_DEF   = 32;
	localparam int ANGLE_BITS_DEF  = 32;
	localparam int TRIG_STAGES_DEF = 24;

	// Sine and cosine are Q1.30 in a 32-bit signed word.
	localparam int TRIG_W  = 32;
	// Internal binary phase: 32 bits is one turn.
	localparam int PHASE_W = 32;
	// Residual angle of the rotation, with headroom.
	localparam int Z_W     = 34;

	localparam logic signed [TRIG_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [PHASE_W-1:0] atan_turn(input int i);
		logic [PHASE_W-1:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/psc_cordic.sv -----
module psc_cordic #(
	parameter int ANGLE_BITS = 32,
	parameter int STAGES     = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [ANGLE_BITS-1:0]             angle,
	output logic                              out_vld,
	output logic signed [psc_pkg::TRIG_W-1:0] sin_val,
	output logic signed [psc_pkg::TRIG_W-1:0] cos_val
);
	import psc_pkg::*;

	localparam logic signed [Z_W-1:0] QUARTER = 34'sh0_4000_0000;
	localparam logic signed [Z_W-1:0] HALF    = 34'sh0_8000_0000;

	logic [PHASE_W-1:0]       phase;
	logic signed [Z_W-1:0]    z_in;
	logic signed [Z_W-1:0]    z_fold;
	logic                     neg_fold;

	logic signed [TRIG_W-1:0] x_s   [0:STAGES];
	logic signed [TRIG_W-1:0] y_s   [0:STAGES];
	logic signed [Z_W-1:0]    z_s   [0:STAGES];
	logic                     neg_s [0:STAGES];
	logic                     vld_s [0:STAGES];

	generate
		if (ANGLE_BITS >= PHASE_W) begin : g_trunc
			assign phase = angle[ANGLE_BITS-1 -: PHASE_W];
		end else begin : g_pad
			assign phase = {angle, {(PHASE_W-ANGLE_BITS){1'b0}}};
		end
	endgenerate

	// Bring the phase into the right half plane; the far half is negated at the end.
	always_comb begin
		z_in = {{(Z_W-PHASE_W){phase[PHASE_W-1]}}, phase};
		z_fold = z_in;
		neg_fold = 1'b0;
		if (z_in > QUARTER) begin
			z_fold = z_in - HALF;
			neg_fold = 1'b1;
		end else if (z_in < -QUARTER) begin
			z_fold = z_in + HALF;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_INV_GAIN;
		y_s[0] <= '0;
		z_s[0] <= z_fold;
		neg_s[0] <= neg_fold;
	end

	genvar gi;
	generate
		for (gi = 0; gi < STAGES; gi++) begin : g_stage
			localparam logic signed [Z_W-1:0] ATAN = {{(Z_W-PHASE_W){1'b0}}, atan_turn(gi)};
			logic signed [TRIG_W-1:0] dx;
			logic signed [TRIG_W-1:0] dy;

			assign dx = y_s[gi] >>> gi;
			assign dy = x_s[gi] >>> gi;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[gi+1] <= 1'b0;
				end else begin
					vld_s[gi+1] <= vld_s[gi];
				end
			end

			always_ff @(posedge clk) begin
				neg_s[gi+1] <= neg_s[gi];
				if (!z_s[gi][Z_W-1]) begin
					x_s[gi+1] <= x_s[gi] - dx;
					y_s[gi+1] <= y_s[gi] + dy;
					z_s[gi+1] <= z_s[gi] - ATAN;
				end else begin
					x_s[gi+1] <= x_s[gi] + dx;
					y_s[gi+1] <= y_s[gi] - dy;
					z_s[gi+1] <= z_s[gi] + ATAN;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sin_val <= neg_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
		cos_val <= neg_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	end

endmodule

// ----- src/psc_rmul.sv -----
module psc_rmul #(
	parameter int IN_W = 32
) (
	input  logic                              clk,
	input  logic signed [IN_W-1:0]            a,
	input  logic signed [psc_pkg::TRIG_W-1:0] t,
	output logic signed [IN_W+1:0]            res_s2
);
	import psc_pkg::*;

	localparam int P_W = IN_W + TRIG_W;
	localparam int O_W = IN_W + 2;

	logic signed [P_W-1:0] prod_s1;
	logic [P_W-1:0]        mag;
	logic [P_W-1:0]        rnd;
	logic signed [O_W-1:0] res_c;

	always_ff @(posedge clk) begin
		prod_s1 <= a * t;
	end

	// Round the magnitude half away from zero, dropping the Q1.30 scale.
	always_comb begin
		mag = prod_s1[P_W-1] ? P_W'(-prod_s1) : P_W'(prod_s1);
		rnd = (mag + (P_W'(1) << 29)) >> 30;
		res_c = prod_s1[P_W-1] ? -$signed(rnd[O_W-1:0]) : $signed(rnd[O_W-1:0]);
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_c;
	end

endmodule

// ----- src/polar_spherical_to_cartesian_unit.sv -----
// Polar and spherical to Cartesian converter. A request is taken on every cycle in which
// start is high; busy is always low, so a new point can enter every clock. Each result
// appears on x_coord, y_coord, z_coord and end_of_set_out for exactly one cycle, marked by
// done, and results leave in request order. The receiver cannot hold results off, so it
// must take each one in the cycle in which done is high. A request passes through the two
// rotation pipelines (one stage per CORDIC iteration plus a fold and a sign stage), then
// two rounded multiply steps of two stages each and an output saturation register.
// In polar mode (mode low) z_coord is zero and polar_angle is ignored; in spherical mode
// r * sin(theta) is formed first at full width and then scaled by cos(phi) and sin(phi).
// All coordinate outputs saturate at the signed DATA_BITS limits.
module polar_spherical_to_cartesian_unit #(
	parameter int DATA_BITS   = psc_pkg::DATA_BITS_DEF,
	parameter int ANGLE_BITS  = psc_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_STAGES = psc_pkg::TRIG_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic signed [DATA_BITS-1:0] radius,
	input  logic [ANGLE_BITS-1:0]       polar_angle,
	input  logic [ANGLE_BITS-1:0]       azimuth,
	input  logic                        end_of_set,
	output logic                        done,
	output logic signed [DATA_BITS-1:0] x_coord,
	output logic signed [DATA_BITS-1:0] y_coord,
	output logic signed [DATA_BITS-1:0] z_coord,
	output logic                        end_of_set_out
);
	import psc_pkg::*;
	`include "polar_spherical_to_cartesian_unit_macros.svh"

	// Depth of the rotation pipelines and the overall request-to-result latency.
	localparam int CL      = TRIG_STAGES + 2;
	localparam int LATENCY = TRIG_STAGES + 7;
	// Width of r * sin(theta) and of the second products after rounding.
	localparam int BW = DATA_BITS + 2;
	localparam int XW = BW + 2;

	localparam logic signed [XW-1:0] SAT_HI = XW'({1'b0, {(DATA_BITS-1){1'b1}}});
	localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

	logic accept;

	// Side data that rides along with the rotation pipelines.
	logic signed [DATA_BITS-1:0] r_d    [0:CL-1];
	logic                        mode_d [0:CL-1];
	logic                        eos_d  [0:CL-1];

	logic                        vld_a;
	logic                        vld_b;
	logic signed [TRIG_W-1:0]    sp_a;
	logic signed [TRIG_W-1:0]    cp_a;
	logic signed [TRIG_W-1:0]    st_a;
	logic signed [TRIG_W-1:0]    ct_a;

	// First multiply step: two stages.
	logic signed [DATA_BITS-1:0] r_s1, r_s2;
	logic                        mode_s1, mode_s2;
	logic                        eos_s1, eos_s2;
	logic                        vld_s1, vld_s2;
	logic signed [TRIG_W-1:0]    sp_s1, sp_s2;
	logic signed [TRIG_W-1:0]    cp_s1, cp_s2;
	logic signed [BW-1:0]        base_s2;
	logic signed [BW-1:0]        zr_s2;

	// Second multiply step: two stages.
	logic signed [BW-1:0]        mul_in;
	logic                        mode_s3, mode_s4;
	logic                        eos_s3, eos_s4;
	logic                        vld_s3, vld_s4;
	logic signed [BW-1:0]        zr_s3, zr_s4;
	logic signed [XW-1:0]        xr_s4;
	logic signed [XW-1:0]        yr_s4;

	function automatic logic signed [DATA_BITS-1:0] sat(input logic signed [XW-1:0] v);
		logic signed [DATA_BITS-1:0] o;
		if (v > SAT_HI) begin
			o = SAT_HI[DATA_BITS-1:0];
		end else if (v < SAT_LO) begin
			o = SAT_LO[DATA_BITS-1:0];
		end else begin
			o = v[DATA_BITS-1:0];
		end
		return o;
	endfunction

	// Every stage advances every cycle, so the block is never busy.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	psc_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.STAGES    (TRIG_STAGES)
	) u_cordic_phi (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.angle  (azimuth),
		.out_vld(vld_a),
		.sin_val(sp_a),
		.cos_val(cp_a)
	);

	psc_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.STAGES    (TRIG_STAGES)
	) u_cordic_theta (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.angle  (polar_angle),
		.out_vld(vld_b),
		.sin_val(st_a),
		.cos_val(ct_a)
	);

	// The radius, mode and end-of-set flag are delayed to meet the sine and cosine.
	always_ff @(posedge clk) begin
		r_d[0]    <= radius;
		mode_d[0] <= mode;
		eos_d[0]  <= end_of_set;
		for (int i = 1; i < CL; i++) begin
			r_d[i]    <= r_d[i-1];
			mode_d[i] <= mode_d[i-1];
			eos_d[i]  <= eos_d[i-1];
		end
	end

	// r * sin(theta) and r * cos(theta), rounded but not saturated.
	psc_rmul #(.IN_W(DATA_BITS)) u_mul_rst (
		.clk   (clk),
		.a     (r_d[CL-1]),
		.t     (st_a),
		.res_s2(base_s2)
	);

	psc_rmul #(.IN_W(DATA_BITS)) u_mul_rct (
		.clk   (clk),
		.a     (r_d[CL-1]),
		.t     (ct_a),
		.res_s2(zr_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld_a;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done   <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		r_s1    <= r_d[CL-1];
		r_s2    <= r_s1;
		mode_s1 <= mode_d[CL-1];
		mode_s2 <= mode_s1;
		eos_s1  <= eos_d[CL-1];
		eos_s2  <= eos_s1;
		sp_s1   <= sp_a;
		sp_s2   <= sp_s1;
		cp_s1   <= cp_a;
		cp_s2   <= cp_s1;
		mode_s3 <= mode_s2;
		mode_s4 <= mode_s3;
		eos_s3  <= eos_s2;
		eos_s4  <= eos_s3;
		zr_s3   <= zr_s2;
		zr_s4   <= zr_s3;
	end

	// Spherical mode scales r * sin(theta); polar mode scales the radius itself.
	assign mul_in = mode_s2 ? base_s2 : {{(BW-DATA_BITS){r_s2[DATA_BITS-1]}}, r_s2};

	psc_rmul #(.IN_W(BW)) u_mul_x (
		.clk   (clk),
		.a     (mul_in),
		.t     (cp_s2),
		.res_s2(xr_s4)
	);

	psc_rmul #(.IN_W(BW)) u_mul_y (
		.clk   (clk),
		.a     (mul_in),
		.t     (sp_s2),
		.res_s2(yr_s4)
	);

	// Output register: saturate to the result width.
	always_ff @(posedge clk) begin
		x_coord        <= sat(xr_s4);
		y_coord        <= sat(yr_s4);
		z_coord        <= mode_s4 ? sat({{(XW-BW){zr_s4[BW-1]}}, zr_s4}) : '0;
		end_of_set_out <= eos_s4;
	end

	// Every taken request is followed by a result marked by done.
	`PSC_ASSERT_DELAY(a_req_to_done, clk, arst_n, accept, done, LATENCY)
	// No result appears without a matching earlier request.
	`PSC_ASSERT_IMPL(a_done_has_req, clk, arst_n, done, $past(start, LATENCY))
	// A polar request always gives a zero z coordinate.
	`PSC_ASSERT_IMPL(a_polar_z_zero, clk, arst_n, done && !$past(mode, LATENCY), z_coord == '0)
	// Both rotation pipelines stay in step.
	`PSC_ASSERT_IMPL(a_trig_in_step, clk, arst_n, 1'b1, vld_a == vld_b)

endmodule
